// ----- rtl/descriptor_slot_allocator_unit_assert.svh -----
// Assertion macros used by the descriptor slot allocator top level
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define DSA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dsa: same-cycle check failed");
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dsa: next-cycle check failed");
`else
`define DSA_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- rtl/dsa_pkg.sv -----
// Types, constants and controller/datapath structs of the descriptor slot allocator
`default_nettype none
package dsa_pkg;
   localparam int MAX_HEAPS      = 8;
   localparam int SLOTS_PER_HEAP = 256;
   localparam int TOTAL_SLOTS    = MAX_HEAPS * SLOTS_PER_HEAP;
   localparam int SLOT_W   = (TOTAL_SLOTS > 1) ? $clog2(TOTAL_SLOTS) : 1;
   localparam int TOP_W    = $clog2(TOTAL_SLOTS + 1);
   localparam int HEAP_W   = (MAX_HEAPS > 1) ? $clog2(MAX_HEAPS) : 1;
   localparam int CNT_W    = $clog2(MAX_HEAPS + 1);
   localparam int QUO_W    = (SLOTS_PER_HEAP > 1) ? $clog2(SLOTS_PER_HEAP) : 1;
   localparam int DIVB_W   = (QUO_W > 1) ? $clog2(QUO_W) : 1;
   localparam int DS_W     = 13;
   localparam int SPAN_W   = DS_W + QUO_W;
   localparam int ADDR_W   = 64;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 3;
   localparam logic [DS_W-1:0] DS_RESET = DS_W'(32);

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ALLOC    = 2'd0,
      FUNC_FREE     = 2'd1,
      FUNC_ADD_HEAP = 2'd2,
      FUNC_NONE     = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 3'd0,
      ST_EXHAUSTED    = 3'd1,
      ST_NO_ROOM      = 3'd2,
      ST_ALREADY_FREE = 3'd3,
      ST_NOT_FOUND    = 3'd4
   } status_type;

   typedef struct packed {
      logic       accept;
      logic       clr_step;
      logic       stack_rd;
      logic       alloc_take;
      logic       alloc_fin;
      logic       search_init;
      logic       search_step;
      logic       div_step;
      logic       bm_rd;
      logic       push;
      logic       heap_add;
      logic       set_status;
      status_type status_code;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic     clr_done;
      func_type func;
      logic     exhausted;
      logic     heap_full;
      logic     idx_end;
      logic     hit;
      logic     div_last;
      logic     allocated;
      logic     top_zero;
   } sts_type;
endpackage
`default_nettype wire

// ----- rtl/dsa_if.sv -----
// Request and response channel interfaces of the descriptor slot allocator
`default_nettype none
interface dsa_req_if;
   import dsa_pkg::*;
   logic                valid;
   logic                ready;
   func_type            func;
   logic [ADDR_W-1:0]   cpu_address;
   logic [ADDR_W-1:0]   gpu_address;
   modport source (output valid, func, cpu_address, gpu_address, input ready);
   modport sink (input valid, func, cpu_address, gpu_address, output ready);
endinterface

interface dsa_rsp_if;
   import dsa_pkg::*;
   logic                valid;
   logic                ready;
   status_type          status;
   logic [ADDR_W-1:0]   slot_cpu_address;
   logic [ADDR_W-1:0]   slot_gpu_address;
   modport source (output valid, status, slot_cpu_address, slot_gpu_address, input ready);
   modport sink (input valid, status, slot_cpu_address, slot_gpu_address, output ready);
endinterface
`default_nettype wire

// ----- rtl/dsa_ctrl.sv -----
// Sequencing state machine of the descriptor slot allocator
`default_nettype none
module dsa_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire dsa_pkg::sts_type sts,
   output dsa_pkg::cmd_type      cmd,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready
);
   import dsa_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DISPATCH, S_ALLOC_TAKE, S_ALLOC_FIN,
      S_SEARCH, S_DIV, S_BM_READ, S_CHECK, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd       = '0;
      cmd.status_code = ST_OK;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            unique case (sts.func)
               FUNC_ALLOC: begin
                  if (sts.exhausted) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_EXHAUSTED;
                     state_in        = S_RESP;
                  end else begin
                     cmd.stack_rd = 1'b1;
                     state_in     = S_ALLOC_TAKE;
                  end
               end
               FUNC_FREE: begin
                  cmd.search_init = 1'b1;
                  state_in        = S_SEARCH;
               end
               FUNC_ADD_HEAP: begin
                  if (sts.heap_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = ST_NO_ROOM;
                  end else begin
                     cmd.heap_add = 1'b1;
                  end
                  state_in = S_RESP;
               end
               default: begin
                  cmd.set_status = 1'b1;
                  state_in       = S_RESP;
               end
            endcase
         end
         S_ALLOC_TAKE: begin
            cmd.alloc_take = 1'b1;
            state_in       = S_ALLOC_FIN;
         end
         S_ALLOC_FIN: begin
            cmd.alloc_fin = 1'b1;
            state_in      = S_RESP;
         end
         S_SEARCH: begin
            if (sts.idx_end) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_NOT_FOUND;
               state_in        = S_RESP;
            end else begin
               cmd.search_step = 1'b1;
               if (sts.hit) state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_BM_READ;
         end
         S_BM_READ: begin
            cmd.bm_rd = 1'b1;
            state_in  = S_CHECK;
         end
         S_CHECK: begin
            if (sts.allocated) begin
               cmd.push = 1'b1;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = ST_ALREADY_FREE;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

// ----- rtl/dsa_dp.sv -----
// Datapath of the descriptor slot allocator: free stack, slot bitmap, heap table, divider
`default_nettype none
module dsa_dp (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire dsa_pkg::cmd_type             cmd,
   output dsa_pkg::sts_type                  sts,
   input  wire logic                         csr_write_enable,
   input  wire logic [dsa_pkg::DS_W-1:0]     csr_write_data,
   input  wire dsa_pkg::func_type            req_func,
   input  wire logic [dsa_pkg::ADDR_W-1:0]   req_cpu_address,
   input  wire logic [dsa_pkg::ADDR_W-1:0]   req_gpu_address,
   output dsa_pkg::status_type               rsp_status,
   output logic [dsa_pkg::ADDR_W-1:0]        rsp_slot_cpu_address,
   output logic [dsa_pkg::ADDR_W-1:0]        rsp_slot_gpu_address
);
   import dsa_pkg::*;

   logic [DS_W-1:0]   ds_ff;
   func_type          func_ff;
   logic [ADDR_W-1:0] cpu_ff, gpu_ff;
   logic [TOP_W-1:0]  top_ff, clr_ff;
   logic [CNT_W-1:0]  count_ff, idx_ff;
   logic [SLOT_W-1:0] stack_q_ff, g_ff;
   logic              bm_q_ff;
   logic [SPAN_W-1:0] off_ff, rem_ff;
   logic [QUO_W-1:0]  q_ff;
   logic [DIVB_W-1:0] bit_ff;
   status_type        res_status_ff, rsp_status_ff;
   logic [ADDR_W-1:0] res_cpu_ff, res_gpu_ff, rsp_cpu_ff, rsp_gpu_ff;

   logic [SLOT_W-1:0] stack_mem [TOTAL_SLOTS];
   logic              bm_mem [TOTAL_SLOTS];
   logic [ADDR_W-1:0] cpu_base_mem [MAX_HEAPS];
   logic [ADDR_W-1:0] gpu_base_mem [MAX_HEAPS];

   logic [TOP_W-1:0]  list_size;
   logic [SPAN_W-1:0] span, trial;
   logic [ADDR_W-1:0] diff;
   logic [HEAP_W-1:0] rd_heap;
   logic [HEAP_W-1:0] g_heap;
   logic [QUO_W-1:0]  g_off, q_next;
   logic              trial_ge;
   logic              stack_we, bm_we, bm_wd;
   logic [SLOT_W-1:0] stack_wa, stack_wd, bm_wa;

   assign list_size = TOP_W'(count_ff) * TOP_W'(SLOTS_PER_HEAP);
   assign span      = SPAN_W'(ds_ff) * SPAN_W'(SLOTS_PER_HEAP);
   assign g_heap    = HEAP_W'(g_ff / SLOT_W'(SLOTS_PER_HEAP));
   assign g_off     = QUO_W'(stack_q_ff % SLOT_W'(SLOTS_PER_HEAP));
   assign rd_heap   = cmd.alloc_fin ? g_heap : idx_ff[HEAP_W-1:0];
   assign diff      = cpu_ff - cpu_base_mem[rd_heap];
   assign trial     = SPAN_W'(ds_ff) << bit_ff;
   assign trial_ge  = rem_ff >= trial;
   assign q_next    = q_ff | (QUO_W'(trial_ge) << bit_ff);

   always_comb begin
      sts           = '0;
      sts.clr_done  = clr_ff == TOP_W'(TOTAL_SLOTS);
      sts.func      = func_ff;
      sts.exhausted = top_ff >= list_size;
      sts.heap_full = count_ff >= CNT_W'(MAX_HEAPS);
      sts.idx_end   = idx_ff >= count_ff;
      sts.hit       = diff < ADDR_W'(span);
      sts.div_last  = bit_ff == '0;
      sts.allocated = bm_q_ff;
      sts.top_zero  = top_ff == '0;
   end

   // write ports of the two slot memories
   always_comb begin
      stack_we = 1'b0;
      stack_wa = clr_ff[SLOT_W-1:0];
      stack_wd = clr_ff[SLOT_W-1:0];
      bm_we    = 1'b0;
      bm_wa    = clr_ff[SLOT_W-1:0];
      bm_wd    = 1'b0;
      if (cmd.clr_step && !sts.clr_done) begin
         stack_we = 1'b1;
         bm_we    = 1'b1;
      end else if (cmd.push) begin
         stack_we = 1'b1;
         stack_wa = SLOT_W'(top_ff - TOP_W'(1));
         stack_wd = g_ff;
         bm_we    = 1'b1;
         bm_wa    = g_ff;
      end else if (cmd.alloc_take) begin
         bm_we = 1'b1;
         bm_wa = stack_q_ff;
         bm_wd = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) stack_mem[stack_wa] <= stack_wd;
      if (cmd.stack_rd) stack_q_ff <= stack_mem[top_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (bm_we) bm_mem[bm_wa] <= bm_wd;
      if (cmd.bm_rd) bm_q_ff <= bm_mem[g_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.heap_add) begin
         cpu_base_mem[count_ff[HEAP_W-1:0]] <= cpu_ff;
         gpu_base_mem[count_ff[HEAP_W-1:0]] <= gpu_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff    <= DS_RESET;
         top_ff   <= '0;
         count_ff <= '0;
         clr_ff   <= '0;
      end else begin
         if (csr_write_enable) ds_ff <= csr_write_data;
         if (cmd.clr_step && !sts.clr_done) clr_ff <= clr_ff + TOP_W'(1);
         if (cmd.alloc_take) top_ff <= top_ff + TOP_W'(1);
         else if (cmd.push) top_ff <= top_ff - TOP_W'(1);
         if (cmd.heap_add) count_ff <= count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff <= req_func;
         cpu_ff  <= req_cpu_address;
         gpu_ff  <= req_gpu_address;
      end
      if (cmd.alloc_take) begin
         g_ff   <= stack_q_ff;
         off_ff <= SPAN_W'(g_off) * SPAN_W'(ds_ff);
      end
      if (cmd.search_init) idx_ff <= '0;
      if (cmd.search_step) begin
         if (sts.hit) begin
            rem_ff <= diff[SPAN_W-1:0];
            q_ff   <= '0;
            bit_ff <= DIVB_W'(QUO_W - 1);
         end else begin
            idx_ff <= idx_ff + CNT_W'(1);
         end
      end
      // one quotient bit per step, restoring
      if (cmd.div_step) begin
         if (trial_ge) rem_ff <= rem_ff - trial;
         q_ff   <= q_next;
         bit_ff <= bit_ff - DIVB_W'(1);
         if (sts.div_last)
            g_ff <= SLOT_W'(SLOT_W'(idx_ff) * SLOT_W'(SLOTS_PER_HEAP)) + SLOT_W'(q_next);
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status_code;
         res_cpu_ff    <= '0;
         res_gpu_ff    <= '0;
      end else if (cmd.alloc_fin) begin
         res_status_ff <= ST_OK;
         res_cpu_ff    <= cpu_base_mem[rd_heap] + ADDR_W'(off_ff);
         res_gpu_ff    <= gpu_base_mem[rd_heap] + ADDR_W'(off_ff);
      end else if (cmd.push || cmd.heap_add) begin
         res_status_ff <= ST_OK;
         res_cpu_ff    <= '0;
         res_gpu_ff    <= '0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_cpu_ff    <= res_cpu_ff;
         rsp_gpu_ff    <= res_gpu_ff;
      end
   end

   assign rsp_status           = rsp_status_ff;
   assign rsp_slot_cpu_address = rsp_cpu_ff;
   assign rsp_slot_gpu_address = rsp_gpu_ff;
endmodule
`default_nettype wire

// ----- rtl/descriptor_slot_allocator_unit.sv -----
// Descriptor slot allocator: stack-shaped free list over up to eight descriptor heaps
//
// Request channel (req_if): func selects alloc, free or add heap; cpu_address is the
// slot to free or the new heap's CPU base, gpu_address the new heap's GPU base.
// Response channel (rsp_if): one transaction per request with status and, for a
// successful alloc, the slot's CPU and GPU addresses (zero otherwise).
// csr_write_enable/csr_write_data set the descriptor size; write only while idle.
// One request is processed at a time. An alloc passes through the dispatch, take and
// finish states before the response load; add heap, an unused func and an exhausted alloc
// go from dispatch to the response load. A free scans the heaps in turn up to the hit, runs
// 8 divide steps, reads the bitmap, checks and loads; a free that matches no heap ends
// after scanning every heap. The next request can be taken in the cycle after the result
// is loaded. The restoring divider and the sequential heap scan set the free latency.
// After reset the block sweeps its 2048-entry free stack and bitmap, one entry a
// cycle; req ready rises once the sweep is done.
// A new request is accepted while a finished response still waits; if the
// receiver stalls, the next result holds until the output register is taken.
`default_nettype none
`include "descriptor_slot_allocator_unit_assert.svh"
module descriptor_slot_allocator_unit (
   input  wire logic                     clock,
   input  wire logic                     reset,
   dsa_req_if.sink                       req_if,
   dsa_rsp_if.source                     rsp_if,
   input  wire logic                     csr_write_enable,
   input  wire logic [dsa_pkg::DS_W-1:0] csr_write_data
);
   import dsa_pkg::*;

   cmd_type cmd;
   sts_type sts;

   dsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready)
   );

   dsa_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data),
      .req_func             (req_if.func),
      .req_cpu_address      (req_if.cpu_address),
      .req_gpu_address      (req_if.gpu_address),
      .rsp_status           (rsp_if.status),
      .rsp_slot_cpu_address (rsp_if.slot_cpu_address),
      .rsp_slot_gpu_address (rsp_if.slot_gpu_address)
   );

   `DSA_ASSERT_SAME(a_ready_after_clear, clock, reset, req_if.ready, sts.clr_done)
   `DSA_ASSERT_SAME(a_pop_not_empty, clock, reset, cmd.stack_rd, !sts.exhausted)
   `DSA_ASSERT_SAME(a_push_has_alloc, clock, reset, cmd.push, !sts.top_zero)
   `DSA_ASSERT_NEXT(a_load_shows_valid, clock, reset, cmd.rsp_load, rsp_if.valid)
endmodule
`default_nettype wire

// ----- bench/descriptor_slot_allocator_unit_tb.sv -----
// Self-checking bench for the descriptor slot allocator: directed table, then random phases
`default_nettype none
module descriptor_slot_allocator_unit_tb;
   import dsa_pkg::*;

   typedef struct {
      status_type        status;
      logic [ADDR_W-1:0] cpu;
      logic [ADDR_W-1:0] gpu;
   } slot_rsp_type;

   typedef struct {
      func_type          func;
      logic [ADDR_W-1:0] cpu;
      logic [ADDR_W-1:0] gpu;
      bit                typed;
      slot_rsp_type      want;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [DS_W-1:0] csr_write_data = '0;

   dsa_req_if req_if();
   dsa_rsp_if rsp_if();

   descriptor_slot_allocator_unit DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // allocator image
   logic [SLOT_W-1:0] slot_stack [TOTAL_SLOTS];
   int                alloc_top;
   int                heap_total;
   logic [ADDR_W-1:0] cpu_base [MAX_HEAPS];
   logic [ADDR_W-1:0] gpu_base [MAX_HEAPS];
   logic [DS_W-1:0]   slot_step;

   slot_rsp_type      pending_rsp [$];
   logic [ADDR_W-1:0] live_cpu [$];
   logic [ADDR_W-1:0] freed_cpu [$];
   table_row_type     stim_table [$];
   int  errors = 0;
   bit  quiet = 1'b0;
   bit  hold_req = 1'b0;

   task automatic report(string what, logic [ADDR_W-1:0] got, logic [ADDR_W-1:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   task automatic predict_slot(func_type f, logic [ADDR_W-1:0] c, logic [ADDR_W-1:0] g,
                               output slot_rsp_type r);
      logic [ADDR_W-1:0] span, diff, off;
      int slot, h;
      bit found;
      r.status = ST_OK;
      r.cpu = '0;
      r.gpu = '0;
      case (f)
         FUNC_ALLOC: begin
            if (alloc_top >= heap_total * SLOTS_PER_HEAP) begin
               r.status = ST_EXHAUSTED;
            end else begin
               slot = int'(slot_stack[alloc_top]);
               alloc_top++;
               h = slot / SLOTS_PER_HEAP;
               if (h >= heap_total) h = 0;
               off = ADDR_W'(slot % SLOTS_PER_HEAP) * ADDR_W'(slot_step);
               r.cpu = cpu_base[h] + off;
               r.gpu = gpu_base[h] + off;
            end
         end
         FUNC_FREE: begin
            span = ADDR_W'(SLOTS_PER_HEAP) * ADDR_W'(slot_step);
            found = 1'b0;
            slot = 0;
            for (int i = 0; i < heap_total && !found; i++) begin
               diff = c - cpu_base[i];
               if (diff < span) begin
                  slot = i * SLOTS_PER_HEAP + int'(diff / ADDR_W'(slot_step));
                  found = 1'b1;
               end
            end
            if (!found) begin
               r.status = ST_NOT_FOUND;
            end else begin
               for (int i = alloc_top; i < heap_total * SLOTS_PER_HEAP; i++)
                  if (slot_stack[i] == slot) found = 1'b0;
               if (!found || alloc_top == 0) begin
                  r.status = ST_ALREADY_FREE;
               end else begin
                  alloc_top--;
                  slot_stack[alloc_top] = SLOT_W'(slot);
               end
            end
         end
         FUNC_ADD_HEAP: begin
            if (heap_total >= MAX_HEAPS) begin
               r.status = ST_NO_ROOM;
            end else begin
               cpu_base[heap_total] = c;
               gpu_base[heap_total] = g;
               for (int i = 0; i < SLOTS_PER_HEAP; i++)
                  slot_stack[heap_total * SLOTS_PER_HEAP + i] =
                     SLOT_W'(heap_total * SLOTS_PER_HEAP + i);
               heap_total++;
            end
         end
         default: ;
      endcase
   endtask

   // offer one transaction, hold valid high until taken; caller drops valid
   task automatic offer(func_type f, logic [ADDR_W-1:0] c, logic [ADDR_W-1:0] g,
                        bit typed, slot_rsp_type want);
      slot_rsp_type r;
      req_if.valid <= 1'b1;
      req_if.func <= f;
      req_if.cpu_address <= c;
      req_if.gpu_address <= g;
      do @(posedge clock); while (!req_if.ready);
      predict_slot(f, c, g, r);
      if (typed) r = want;
      if (f == FUNC_ALLOC && r.status == ST_OK) live_cpu.insert(live_cpu.size(), r.cpu);
      pending_rsp.insert(pending_rsp.size(), r);
   endtask

   task automatic idle_gap();
      int n;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         n = $urandom_range(1, 8);
         req_if.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic settle_and_write(logic [DS_W-1:0] v);
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      slot_step = v;
   endtask

   function automatic table_row_type mk(func_type f, logic [ADDR_W-1:0] c,
                                        logic [ADDR_W-1:0] g,
                                        bit typed = 0, status_type s = ST_OK,
                                        logic [ADDR_W-1:0] wc = '0,
                                        logic [ADDR_W-1:0] wg = '0);
      table_row_type t;
      t.func = f;
      t.cpu = c;
      t.gpu = g;
      t.typed = typed;
      t.want.status = s;
      t.want.cpu = wc;
      t.want.gpu = wg;
      return t;
   endfunction

   function automatic void add_row(table_row_type t);
      stim_table.insert(stim_table.size(), t);
   endfunction

   // response side: random stalls, one long hold-off on request
   initial begin
      slot_rsp_type w;
      int n;
      forever begin
         if (hold_req) begin
            rsp_if.ready <= 1'b0;
            for (n = 0; n < 400; n++) @(posedge clock);
            hold_req = 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
            if (rsp_if.valid && rsp_if.ready) begin
               if (pending_rsp.size() == 0) begin
                  report("unexpected transaction", rsp_if.slot_cpu_address, '0);
               end else begin
                  w = pending_rsp.pop_front();
                  if (rsp_if.status != w.status)
                     report("status", ADDR_W'(rsp_if.status), ADDR_W'(w.status));
                  if (rsp_if.slot_cpu_address != w.cpu)
                     report("slot_cpu_address", rsp_if.slot_cpu_address, w.cpu);
                  if (rsp_if.slot_gpu_address != w.gpu)
                     report("slot_gpu_address", rsp_if.slot_gpu_address, w.gpu);
               end
            end
         end
      end
   end

   initial begin
      #5000000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      logic [DS_W-1:0] steps [6];
      int alloc_pct [6];
      slot_rsp_type none;
      logic [ADDR_W-1:0] c, g;
      func_type f;
      int pick;
      none = '{ST_OK, '0, '0};
      for (int i = 0; i < TOTAL_SLOTS; i++) slot_stack[i] = SLOT_W'(i);
      alloc_top = 0;
      heap_total = 0;
      slot_step = DS_RESET;
      req_if.valid <= 1'b0;
      req_if.func <= FUNC_ALLOC;
      req_if.cpu_address <= '0;
      req_if.gpu_address <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row(mk(FUNC_ALLOC, '0, '0, 1, ST_EXHAUSTED));
      add_row(mk(FUNC_FREE, '0, '0, 1, ST_NOT_FOUND));
      add_row(mk(FUNC_FREE, '1, '1, 1, ST_NOT_FOUND));
      add_row(mk(FUNC_NONE, '1, '1, 1, ST_OK));
      add_row(mk(FUNC_ADD_HEAP, 64'hFFFF_FFFF_FFFF_FFF0, '0, 1, ST_OK));
      add_row(mk(FUNC_ALLOC, '0, '0, 1, ST_OK, 64'hFFFF_FFFF_FFFF_FFF0, '0));
      // second slot wraps past the top of the address space
      add_row(mk(FUNC_ALLOC, '1, '1));
      add_row(mk(FUNC_FREE, 64'h15, '0));
      add_row(mk(FUNC_FREE, 64'h15, '0));
      add_row(mk(FUNC_FREE, 64'hFFFF_FFFF_FFFF_FFF0, '0));
      add_row(mk(FUNC_FREE, 64'hFFFF_FFFF_FFFF_FFF0, '0));
      add_row(mk(FUNC_FREE, 64'h10_0000, '0, 1, ST_NOT_FOUND));
      add_row(mk(FUNC_ADD_HEAP, '0, '1, 1, ST_OK));
      add_row(mk(FUNC_FREE, 64'h20, '0));
      add_row(mk(FUNC_ALLOC, '0, '0));
      add_row(mk(FUNC_NONE, '0, '0, 1, ST_OK));
      foreach (stim_table[i]) begin
         offer(stim_table[i].func, stim_table[i].cpu, stim_table[i].gpu,
               stim_table[i].typed, stim_table[i].want);
         idle_gap();
      end
      live_cpu.delete();

      steps = '{13'd32, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd7};
      alloc_pct = '{88, 55, 40, 60, 50, 55};
      steps[5] = DS_W'($urandom_range(2, 8191));
      for (int p = 0; p < 6; p++) begin
         settle_and_write(steps[p]);
         if (p == 1) hold_req = 1'b1;
         for (int k = 0; k < 275; k++) begin
            if (p == 5 && k >= 150) quiet = 1'b1;
            c = {$urandom, $urandom};
            g = {$urandom, $urandom};
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
               f = FUNC_ADD_HEAP;
            end else if (pick < 4) begin
               f = FUNC_NONE;
            end else if (pick < 4 + alloc_pct[p] * 96 / 100) begin
               f = FUNC_ALLOC;
            end else begin
               f = FUNC_FREE;
               pick = $urandom_range(0, 99);
               if (pick < 70 && live_cpu.size() != 0) begin
                  pick = $urandom_range(0, live_cpu.size() - 1);
                  c = live_cpu[pick];
                  live_cpu.delete(pick);
                  freed_cpu.insert(freed_cpu.size(), c);
                  if (freed_cpu.size() > 32) void'(freed_cpu.pop_front());
                  if (slot_step != 0) c = c + ADDR_W'($urandom_range(0, slot_step - 1));
               end else if (pick < 85 && freed_cpu.size() != 0) begin
                  c = freed_cpu[$urandom_range(0, freed_cpu.size() - 1)];
               end else if (pick < 93 && heap_total != 0) begin
                  c = cpu_base[$urandom_range(0, heap_total - 1)] + ADDR_W'($urandom_range(0, 1 << 21));
               end
            end
            offer(f, c, g, 0, none);
            idle_gap();
         end
      end
      req_if.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/dsa_pkg.sv
rtl/dsa_if.sv
rtl/dsa_ctrl.sv
rtl/dsa_dp.sv
rtl/descriptor_slot_allocator_unit.sv
bench/descriptor_slot_allocator_unit_tb.sv
